### hw/rtl/vic_pkg.sv
// Shared types, codes and constants of the valve injection controller.
// No dependencies; every other file imports this package.
package vic_pkg;

    // Coil drive codes of a result item
    typedef enum logic [2:0] {
        DRV_NONE       = 3'd0,
        DRV_PULSE_FWD  = 3'd1,
        DRV_PULSE_REV  = 3'd2,
        DRV_STEADY_FWD = 3'd3,
        DRV_RELEASE    = 3'd4
    } t_drive;

    // Supply status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_DISCONNECTED = 2'd1;
    localparam logic [1:0] ST_SHORT        = 2'd2;
    localparam logic [1:0] ST_SUPPLY_FAULT = 2'd3;

    // Injection modes
    localparam logic [1:0] MODE_DISABLED = 2'd0;
    localparam logic [1:0] MODE_AUTO     = 2'd1;
    localparam logic [1:0] MODE_FORCED   = 2'd2;

    // Valve kinds
    localparam logic [1:0] KIND_NORM_OPEN   = 2'd0;
    localparam logic [1:0] KIND_NORM_CLOSED = 2'd1;
    localparam logic [1:0] KIND_BISTABLE    = 2'd2;
    localparam logic [1:0] KIND_BISTABLE_INV = 2'd3;

    // Operations of an input item
    localparam logic OP_MEASURE    = 1'b0;
    localparam logic OP_PULSE_DONE = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_OPEN_LEVEL     = 3'd0;
    localparam logic [2:0] REG_CLOSE_LEVEL    = 3'd1;
    localparam logic [2:0] REG_VALVE_KIND     = 3'd2;
    localparam logic [2:0] REG_PULSE_REPEATS  = 3'd3;
    localparam logic [2:0] REG_INJ_MODE       = 3'd4;
    localparam logic [2:0] REG_PULSE_TIME_US  = 3'd5;
    localparam logic [2:0] REG_VALVE_ACTIVE   = 3'd6;
    localparam logic [2:0] REG_SAT_SELECT     = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_OPEN_LEVEL     = 16'd600;
    localparam logic [15:0] RST_CLOSE_LEVEL    = 16'd800;
    localparam logic [1:0]  RST_VALVE_KIND     = KIND_BISTABLE;
    localparam logic [7:0]  RST_PULSE_REPEATS  = 8'd3;
    localparam logic [1:0]  RST_INJ_MODE       = MODE_DISABLED;
    localparam logic [19:0] RST_PULSE_TIME_US  = 20'd100000;

    // Supply voltage window at pulse end, millivolts
    localparam logic [15:0] FINISH_MAX_MV = 16'd7000;
    localparam logic [15:0] FINISH_MIN_MV = 16'd4000;

    typedef struct packed {
        logic [15:0] open_level;
        logic [15:0] close_level;
        logic [1:0]  valve_kind;
        logic [7:0]  pulse_repeats;
        logic [1:0]  inj_mode;
        logic [19:0] pulse_time_us;
        logic        valve_active;
        logic        sat_select;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic [15:0] saturation;
        logic [15:0] concentration;
        logic        sensor_good;
        logic        sensor_is_oxygen;
        logic        supply_ok;
        logic [15:0] finish_mv;
    } t_item;

    typedef struct packed {
        t_drive      drive;
        logic [19:0] pulse_length;
        logic [1:0]  status;
        logic        valve_open;
        logic [7:0]  repeats_left;
        logic        last;
    } t_result;

    // Up to two results caused by one item
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_res_pair;

    // One open or close command: result plus valve state after it
    typedef struct packed {
        logic       valid;
        logic       is_open;
        logic [7:0] rem;
        t_result    res;
    } t_act;

    function automatic t_act actuate(input t_cfg cfg, input logic dir_open,
                                     input logic is_open, input logic [7:0] rem);
        t_act a;
        a = '0;
        a.is_open = is_open;
        a.rem     = rem;
        priority if (cfg.valve_kind == KIND_NORM_OPEN) begin
            a.valid     = 1'b1;
            a.res.drive = dir_open ? DRV_RELEASE : DRV_STEADY_FWD;
        end else if (cfg.valve_kind == KIND_NORM_CLOSED) begin
            a.valid     = 1'b1;
            a.res.drive = dir_open ? DRV_STEADY_FWD : DRV_RELEASE;
        end else begin
            // Reload the pulse count on a change of direction
            if (dir_open != is_open) begin
                a.is_open = dir_open;
                a.rem     = cfg.pulse_repeats;
            end
            if (a.rem != 8'd0) begin
                a.valid = 1'b1;
                a.rem   = a.rem - 8'd1;
                if (cfg.valve_kind == KIND_BISTABLE)
                    a.res.drive = dir_open ? DRV_PULSE_FWD : DRV_PULSE_REV;
                else
                    a.res.drive = dir_open ? DRV_PULSE_REV : DRV_PULSE_FWD;
                a.res.pulse_length = cfg.pulse_time_us;
            end
        end
        a.res.status       = ST_OK;
        a.res.valve_open   = a.is_open;
        a.res.repeats_left = a.rem;
        a.res.last         = 1'b0;
        return a;
    endfunction

endpackage

### hw/rtl/vic_core.sv
// Decision logic and valve state: turns one registered item into up to two results.
// Depends on vic_pkg.
module vic_core
    import vic_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_item     i_item,
    input  logic      i_fire,
    output t_res_pair o_pair
);

    logic       r_is_open, n_is_open;
    logic [7:0] r_rem, n_rem;

    t_act       a_open, a_close, a_single;
    logic [15:0] level;
    logic        below_open, above_close, mid_open;
    logic [7:0]  mid_rem;
    t_result     done_res;
    t_res_pair   pair;

    // Two chained commands: open first, then close from the state it leaves
    assign level       = i_cfg.sat_select ? i_item.saturation : i_item.concentration;
    assign below_open  = level < i_cfg.open_level;
    assign above_close = level > i_cfg.close_level;
    assign a_open      = actuate(i_cfg, 1'b1, r_is_open, r_rem);
    assign mid_open    = below_open ? a_open.is_open : r_is_open;
    assign mid_rem     = below_open ? a_open.rem : r_rem;
    assign a_close     = actuate(i_cfg, 1'b0, mid_open, mid_rem);
    assign a_single    = actuate(i_cfg, ~r_is_open, r_is_open, r_rem);

    // Pulse-done report: classify the supply voltage
    always_comb begin
        done_res = '0;
        done_res.drive        = DRV_NONE;
        done_res.valve_open   = r_is_open;
        done_res.repeats_left = r_rem;
        done_res.last         = 1'b1;
        priority if (!i_item.supply_ok)              done_res.status = ST_SUPPLY_FAULT;
        else if (i_item.finish_mv > FINISH_MAX_MV)   done_res.status = ST_DISCONNECTED;
        else if (i_item.finish_mv < FINISH_MIN_MV)   done_res.status = ST_SHORT;
        else                                          done_res.status = ST_OK;
    end

    // Collect results and next state
    always_comb begin
        pair      = '0;
        n_is_open = r_is_open;
        n_rem     = r_rem;
        if (i_item.op == OP_PULSE_DONE) begin
            pair.count = 2'd1;
            pair.res0  = done_res;
        end else if (i_cfg.valve_active && i_item.sensor_is_oxygen) begin
            if (i_cfg.inj_mode == MODE_AUTO) begin
                if (i_item.sensor_good) begin
                    if (above_close) begin
                        n_is_open = a_close.is_open;
                        n_rem     = a_close.rem;
                    end else begin
                        n_is_open = mid_open;
                        n_rem     = mid_rem;
                    end
                    if (below_open && a_open.valid) begin
                        pair.count = 2'd1;
                        pair.res0  = a_open.res;
                        if (above_close && a_close.valid) begin
                            pair.count = 2'd2;
                            pair.res1  = a_close.res;
                        end
                    end else if (above_close && a_close.valid) begin
                        pair.count = 2'd1;
                        pair.res0  = a_close.res;
                    end
                end
            end else if ((i_cfg.inj_mode == MODE_DISABLED && r_is_open) ||
                         (i_cfg.inj_mode == MODE_FORCED && !r_is_open)) begin
                n_is_open = a_single.is_open;
                n_rem     = a_single.rem;
                if (a_single.valid) begin
                    pair.count = 2'd1;
                    pair.res0  = a_single.res;
                end
            end
        end
        // Mark the final result of this item
        if (pair.count == 2'd2) pair.res1.last = 1'b1;
        else                    pair.res0.last = 1'b1;
    end

    assign o_pair = pair;

    // Advance valve state on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_open <= 1'b0;
            r_rem     <= 8'd0;
        end else if (i_fire) begin
            r_is_open <= n_is_open;
            r_rem     <= n_rem;
        end
    end

endmodule

### hw/rtl/vic_rqueue.sv
// Two-entry result queue; each entry holds the result group of one item.
// Depends on vic_pkg.
module vic_rqueue
    import vic_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_res_pair i_pair,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result   o_res
);

    t_res_pair  r_q [2];
    logic       r_wr, r_rd, r_sub;
    logic [1:0] r_cnt;

    t_res_pair  head;
    logic       out_fire, pop;

    assign head     = r_q[r_rd];
    assign o_res    = r_sub ? head.res1 : head.res0;
    assign o_valid  = (r_cnt != 2'd0);
    assign out_fire = o_valid && i_ready;
    assign pop      = out_fire && o_res.last;
    assign o_room   = (r_cnt != 2'd2) || pop;

    // Hold payload of pushed groups
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_pair;
    end

    // Advance pointers, count and result index within the head group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_sub <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (pop)    r_rd <= ~r_rd;
            if (out_fire) r_sub <= ~o_res.last;
            unique case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hw/rtl/valve_injection_controller_unit.sv
// Valve injection controller: one instance per valve. Top level with config registers.
// Depends on vic_pkg, vic_core, vic_rqueue.
//
// The block takes one item per cycle while the result queue has room. An item is
// captured in an input register, evaluated in one pass against the valve state and,
// if it causes one or two results, pushed as a group into a two-entry result queue;
// its first result is offered once that group has been written into the queue.
// The output side delivers one result per cycle while the receiver is ready, so
// an item that both opens and closes the valve delivers its two results in turn.
// Items that cause no result (inactive valve, non-oxygen sensor, no command due)
// pass without output. Configuration is written through a plain write port and
// must only change while the block is idle.
module valve_injection_controller_unit
    import vic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [19:0] i_cfg_wdata,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [15:0] i_saturation,
    input  logic [15:0] i_concentration,
    input  logic        i_sensor_good,
    input  logic        i_sensor_is_oxygen,
    input  logic        i_supply_ok,
    input  logic [15:0] i_finish_mv,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_drive,
    output logic [19:0] o_pulse_length,
    output logic [1:0]  o_status,
    output logic        o_valve_open,
    output logic [7:0]  o_repeats_left,
    output logic        o_last
);

    t_cfg      r_cfg;
    t_item     r_item;
    logic      r_in_valid;
    logic      room, fire;
    t_res_pair pair;
    t_result   res;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_level     <= RST_OPEN_LEVEL;
            r_cfg.close_level    <= RST_CLOSE_LEVEL;
            r_cfg.valve_kind     <= RST_VALVE_KIND;
            r_cfg.pulse_repeats  <= RST_PULSE_REPEATS;
            r_cfg.inj_mode       <= RST_INJ_MODE;
            r_cfg.pulse_time_us  <= RST_PULSE_TIME_US;
            r_cfg.valve_active   <= 1'b0;
            r_cfg.sat_select     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_OPEN_LEVEL:     r_cfg.open_level     <= i_cfg_wdata[15:0];
                REG_CLOSE_LEVEL:    r_cfg.close_level    <= i_cfg_wdata[15:0];
                REG_VALVE_KIND:     r_cfg.valve_kind     <= i_cfg_wdata[1:0];
                REG_PULSE_REPEATS:  r_cfg.pulse_repeats  <= i_cfg_wdata[7:0];
                REG_INJ_MODE:       r_cfg.inj_mode       <= i_cfg_wdata[1:0];
                REG_PULSE_TIME_US:  r_cfg.pulse_time_us  <= i_cfg_wdata;
                REG_VALVE_ACTIVE:   r_cfg.valve_active   <= i_cfg_wdata[0];
                REG_SAT_SELECT:     r_cfg.sat_select     <= i_cfg_wdata[0];
            endcase
        end
    end

    // Process the held item once the queue has room
    assign fire       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.op               <= i_op;
            r_item.saturation       <= i_saturation;
            r_item.concentration    <= i_concentration;
            r_item.sensor_good      <= i_sensor_good;
            r_item.sensor_is_oxygen <= i_sensor_is_oxygen;
            r_item.supply_ok        <= i_supply_ok;
            r_item.finish_mv        <= i_finish_mv;
        end
    end

    vic_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (r_item),
        .i_fire  (fire),
        .o_pair  (pair)
    );

    vic_rqueue u_rqueue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && (pair.count != 2'd0)),
        .i_pair  (pair),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res)
    );

    assign o_drive        = res.drive;
    assign o_pulse_length = res.pulse_length;
    assign o_status       = res.status;
    assign o_valve_open   = res.valve_open;
    assign o_repeats_left = res.repeats_left;
    assign o_last         = res.last;

endmodule
